[rtl/eqs_pkg.sv]
// ----------------------------------------------------------------------------
// eqs_pkg
// Shared types, codes and defaults of the empirical quality sampler.
// ----------------------------------------------------------------------------
package eqs_pkg;

    localparam int DEF_MAX_POSITIONS = 256;
    localparam int DEF_MAX_ENTRIES   = 64;
    localparam int DEF_DIST_SCALE    = 1000000;

    localparam int QUAL_W     = 7;
    localparam int RND_W      = 20;
    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int PADDR_W    = 5;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_POS   = 2'd1,
        ST_NOENT = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_SEPARATE = 3'd0,
        REG_SHIFT_1  = 3'd1,
        REG_SHIFT_2  = 3'd2,
        REG_MIN_Q    = 3'd3,
        REG_MAX_Q    = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_LOWQ,
        RES_POS,
        RES_NOENT,
        RES_HIT
    } t_res;

    typedef struct packed {
        logic              separate;
        logic signed [7:0] shift_first;
        logic signed [7:0] shift_second;
        logic [6:0]        min_q;
        logic [6:0]        max_q;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic fill_rd;
        logic mul;
        logic div_init;
        logic div_step;
        logic last_rd;
        logic load_wr;
        logic scan_rd;
        logic scan_first;
        logic clr_wr;
        logic res_set;
        t_res res;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic unknown;
        logic pos_bad;
        logic fill_zero;
        logic div_done;
        logic scan_hit;
        logic scan_end;
        logic clr_done;
    } t_sts;

endpackage

[rtl/eqs_ctrl.sv]
// ----------------------------------------------------------------------------
// eqs_ctrl
// Sequencer: steps each item through decode, divide, table scan or clear.
// ----------------------------------------------------------------------------
module eqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  logic          i_out_free,
    output logic          o_emit,
    output eqs_pkg::t_cmd o_cmd,
    input  eqs_pkg::t_sts i_sts
);
    import eqs_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_LD_FILL, S_LD_DIV,
        S_SM_FILL, S_SCAN, S_CLEAR, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_cmd.res = RES_ZERO;
        o_s_ready = 1'b0;
        o_emit    = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
                if (i_s_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_NOP: begin
                        o_cmd.res_set = 1'b1;
                        n_state       = S_DONE;
                    end
                    OP_CLEAR: n_state = S_CLEAR;
                    default: begin
                        if (i_sts.unknown) begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res     = RES_LOWQ;
                            n_state       = S_DONE;
                        end else if (i_sts.pos_bad) begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res     = RES_POS;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.fill_rd = 1'b1;
                            if (i_sts.op == OP_LOAD) begin
                                o_cmd.mul = 1'b1;
                                n_state   = S_LD_FILL;
                            end else begin
                                n_state = S_SM_FILL;
                            end
                        end
                    end
                endcase
            end
            S_LD_FILL: begin
                o_cmd.div_init = 1'b1;
                o_cmd.last_rd  = 1'b1;
                n_state        = S_LD_DIV;
            end
            S_LD_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.load_wr = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SM_FILL: begin
                if (i_sts.fill_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res     = RES_POS;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.scan_rd    = 1'b1;
                    o_cmd.scan_first = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res     = RES_HIT;
                    n_state       = S_DONE;
                end else if (i_sts.scan_end) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res     = RES_NOENT;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.res_set = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

[rtl/eqs_dp.sv]
// ----------------------------------------------------------------------------
// eqs_dp
// Datapath: item registers, row fill memory, entry tables, threshold divider.
// ----------------------------------------------------------------------------
module eqs_dp #(
    parameter int MAX_POSITIONS = eqs_pkg::DEF_MAX_POSITIONS,
    parameter int MAX_ENTRIES   = eqs_pkg::DEF_MAX_ENTRIES,
    parameter int DIST_SCALE    = eqs_pkg::DEF_DIST_SCALE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  eqs_pkg::t_cmd                  i_cmd,
    output eqs_pkg::t_sts                  o_sts,
    input  eqs_pkg::t_cfg                  i_cfg,
    input  logic [eqs_pkg::IN_DATA_W-1:0]  i_data,
    input  logic [eqs_pkg::IN_USER_W-1:0]  i_user,
    output logic [eqs_pkg::QUAL_W-1:0]     o_quality,
    output logic [1:0]                     o_status
);
    import eqs_pkg::*;

    localparam int PB    = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int EB    = $clog2(MAX_ENTRIES);
    localparam int FB    = $clog2(MAX_ENTRIES + 1);
    localparam int TW    = $clog2(DIST_SCALE + 1);
    localparam int SW    = TW;
    localparam int RB    = 3 + PB;
    localparam int AB    = RB + EB;
    localparam int NW    = 32 + SW + 1;
    localparam int CW    = (TW > RND_W) ? TW : RND_W;
    localparam int DCW   = $clog2(TW + 1);
    localparam int ROWS  = 1 << RB;
    localparam int DEPTH = 1 << AB;

    // captured item
    t_op         r_op;
    logic        r_rd;
    logic [2:0]  r_base;
    logic [7:0]  r_pos;
    logic [31:0] r_cum;
    logic [31:0] r_tot;
    logic [6:0]  r_eq;
    logic [19:0] r_rnd;
    logic [3:0]  r_lowq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_user[1:0]);
            r_rd   <= i_user[2];
            r_base <= i_data[2:0];
            r_pos  <= i_data[10:3];
            r_cum  <= i_data[42:11];
            r_tot  <= i_data[74:43];
            r_eq   <= i_data[81:75];
            r_rnd  <= i_data[101:82];
            r_lowq <= i_data[105:102];
        end
    end

    logic          unknown;
    logic [1:0]    slot;
    logic [PB-1:0] pos_idx;
    logic [RB-1:0] row;

    assign unknown = i_cfg.separate && (r_base > 3'd3);
    assign slot    = i_cfg.separate ? r_base[1:0] : 2'd0;
    assign pos_idx = PB'(r_pos);
    assign row     = {r_rd, slot, pos_idx};

    // row fill memory with clear sweep
    logic [FB-1:0] fill_mem [ROWS];
    logic [FB-1:0] r_fill_q;
    logic [RB-1:0] r_cidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cidx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_cidx <= r_cidx + RB'(1);
        end
    end

    // threshold divider
    logic [NW-1:0]  r_prod;
    logic [31:0]    r_rem;
    logic [TW-1:0]  r_dlo;
    logic [TW-1:0]  r_quo;
    logic [DCW-1:0] r_dcnt;
    logic [SW-1:0]  scale_c;
    logic [NW-1:0]  numer;
    logic           sat;
    logic [32:0]    sh;
    logic [33:0]    diff;

    assign scale_c = SW'(DIST_SCALE);
    assign numer   = r_prod + NW'(r_tot) - NW'(1);
    assign sat     = (r_tot == 32'd0) || (r_cum > r_tot);
    assign sh      = {r_rem, r_dlo[TW-1]};
    assign diff    = {1'b0, sh} - {2'b00, r_tot};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_prod <= NW'(r_cum) * NW'(scale_c);
        if (i_cmd.div_init) begin
            r_rem <= 32'(numer >> TW);
            r_dlo <= numer[TW-1:0];
            r_quo <= sat ? TW'(DIST_SCALE) : '0;
        end else if (i_cmd.div_step) begin
            r_rem <= diff[33] ? sh[31:0] : diff[31:0];
            r_dlo <= {r_dlo[TW-2:0], 1'b0};
            r_quo <= {r_quo[TW-2:0], ~diff[33]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_init) begin
            r_dcnt <= sat ? '0 : DCW'(TW);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCW'(1);
        end
    end

    // entry tables
    logic [TW-1:0] thr_mem  [DEPTH];
    logic [6:0]    qual_mem [DEPTH];
    logic [TW-1:0] r_thr_q;
    logic [6:0]    r_qual_q;
    logic [FB-1:0] r_idx;
    logic [EB-1:0] last_idx;
    logic [EB-1:0] scan_idx;
    logic [EB-1:0] wr_idx;
    logic          ow;
    logic          full;
    logic          append;

    assign last_idx = EB'(r_fill_q - FB'(1));
    assign scan_idx = i_cmd.scan_first ? '0 : r_idx[EB-1:0];
    assign ow       = (r_fill_q != '0) && (r_thr_q == r_quo);
    assign full     = r_fill_q >= FB'(MAX_ENTRIES);
    assign append   = !ow && !full;
    assign wr_idx   = ow ? last_idx : r_fill_q[EB-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            fill_mem[r_cidx] <= '0;
        end else if (i_cmd.load_wr && append) begin
            fill_mem[row] <= r_fill_q + FB'(1);
        end
        if (i_cmd.fill_rd) r_fill_q <= fill_mem[row];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && append) thr_mem[{row, wr_idx}] <= r_quo;
        if (i_cmd.load_wr && (ow || !full)) qual_mem[{row, wr_idx}] <= r_eq;
        if (i_cmd.last_rd || i_cmd.scan_rd) begin
            r_thr_q  <= thr_mem[{row, i_cmd.last_rd ? last_idx : scan_idx}];
            r_qual_q <= qual_mem[{row, i_cmd.last_rd ? last_idx : scan_idx}];
        end
        if (i_cmd.scan_rd) begin
            r_idx <= (i_cmd.scan_first ? FB'(0) : r_idx) + FB'(1);
        end
    end

    // shift and clamp
    logic signed [9:0] v_sum;
    logic signed [9:0] v_lo;
    logic signed [9:0] min10;
    logic signed [9:0] max10;
    logic [7:0]        shift;
    logic [6:0]        hit_q;

    assign shift = r_rd ? i_cfg.shift_second : i_cfg.shift_first;
    assign min10 = $signed({3'b000, i_cfg.min_q});
    assign max10 = $signed({3'b000, i_cfg.max_q});
    assign v_sum = $signed({3'b000, r_qual_q}) + $signed({{2{shift[7]}}, shift});
    assign v_lo  = (v_sum < min10) ? min10 : v_sum;
    assign hit_q = (v_lo > max10) ? i_cfg.max_q : v_lo[6:0];

    logic [6:0] r_q;
    logic [1:0] r_st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_q  <= '0;
            r_st <= (!ow && full) ? ST_FULL : ST_OK;
        end else if (i_cmd.res_set) begin
            case (i_cmd.res)
                RES_LOWQ: begin
                    r_q  <= (r_op == OP_SAMPLE) ? {3'b000, r_lowq} : '0;
                    r_st <= ST_OK;
                end
                RES_POS: begin
                    r_q  <= '0;
                    r_st <= ST_POS;
                end
                RES_NOENT: begin
                    r_q  <= '0;
                    r_st <= ST_NOENT;
                end
                RES_HIT: begin
                    r_q  <= hit_q;
                    r_st <= ST_OK;
                end
                default: begin
                    r_q  <= '0;
                    r_st <= ST_OK;
                end
            endcase
        end
    end

    assign o_quality = r_q;
    assign o_status  = r_st;

    assign o_sts.op        = r_op;
    assign o_sts.unknown   = unknown;
    assign o_sts.pos_bad   = {24'd0, r_pos} >= 32'(MAX_POSITIONS);
    assign o_sts.fill_zero = r_fill_q == '0;
    assign o_sts.div_done  = r_dcnt == '0;
    assign o_sts.scan_hit  = CW'(r_thr_q) >= CW'(r_rnd);
    assign o_sts.scan_end  = r_idx == r_fill_q;
    assign o_sts.clr_done  = &r_cidx;

endmodule

[rtl/empirical_quality_sampler.sv]
// ----------------------------------------------------------------------------
// empirical_quality_sampler
// Inverse-CDF quality tables per read, position and base, with sampling.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives one result beat. A sample
// visits the row's table entries in order, up to MAX_ENTRIES of them,
// and the scan reads one entry per cycle from the single table read port.
// A load computes its threshold in the bit-per-cycle divider, which gives a
// TW-bit quotient, TW being the bit width of DIST_SCALE.
// A clear sweeps the row fill memory one row per cycle over all 8 * 2**ceil(
// log2(MAX_POSITIONS)) rows (2048 by default), and the same sweep runs after
// reset before the first beat is taken; register writes are taken meanwhile.
// A finished result waits in the output register while the next beat enters.
// ----------------------------------------------------------------------------
module empirical_quality_sampler #(
    parameter int MAX_POSITIONS = eqs_pkg::DEF_MAX_POSITIONS,
    parameter int MAX_ENTRIES   = eqs_pkg::DEF_MAX_ENTRIES,
    parameter int DIST_SCALE    = eqs_pkg::DEF_DIST_SCALE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: base_code[2:0], position[10:3], cumulative_count[42:11],
    //        row_total[74:43], entry_quality[81:75], random_value[101:82],
    //        low_quality[105:102], zero fill above
    input  logic [eqs_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser: command[1:0], read_select[2]
    input  logic [eqs_pkg::IN_USER_W-1:0]   i_s_tuser,
    // master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: quality[6:0], status[8:7], zero fill above
    output logic [eqs_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eqs_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import eqs_pkg::*;

    // configuration registers
    t_cfg r_cfg;
    t_reg reg_sel;

    assign reg_sel = t_reg'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separate     <= 1'b0;
            r_cfg.shift_first  <= '0;
            r_cfg.shift_second <= '0;
            r_cfg.min_q        <= 7'd0;
            r_cfg.max_q        <= 7'd93;
        end else if (psel && penable && pwrite) begin
            // drop writes beyond the register list
            case (reg_sel)
                REG_SEPARATE: r_cfg.separate     <= pwdata[0];
                REG_SHIFT_1:  r_cfg.shift_first  <= pwdata[7:0];
                REG_SHIFT_2:  r_cfg.shift_second <= pwdata[7:0];
                REG_MIN_Q:    r_cfg.min_q        <= pwdata[6:0];
                REG_MAX_Q:    r_cfg.max_q        <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SEPARATE: prdata = {31'd0, r_cfg.separate};
            REG_SHIFT_1:  prdata = {{24{r_cfg.shift_first[7]}}, r_cfg.shift_first};
            REG_SHIFT_2:  prdata = {{24{r_cfg.shift_second[7]}}, r_cfg.shift_second};
            REG_MIN_Q:    prdata = {25'd0, r_cfg.min_q};
            REG_MAX_Q:    prdata = {25'd0, r_cfg.max_q};
            default:      prdata = 32'd0;
        endcase
    end

    // sequencer and datapath
    t_cmd       cmd;
    t_sts       sts;
    logic       emit;
    logic       out_free;
    logic [6:0] res_q;
    logic [1:0] res_st;

    logic                  r_m_tvalid;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    // the output register frees when empty or taken in this cycle
    assign out_free = !r_m_tvalid || i_m_tready;

    eqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_tvalid),
        .o_s_ready  (o_s_tready),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    eqs_dp #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_ENTRIES   (MAX_ENTRIES),
        .DIST_SCALE    (DIST_SCALE)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_cfg     (r_cfg),
        .i_data    (i_s_tdata),
        .i_user    (i_s_tuser),
        .o_quality (res_q),
        .o_status  (res_st)
    );

    // output register: hold the beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (emit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_m_tdata <= {7'd0, res_st, res_q};
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

[dv/empirical_quality_sampler_tb.sv]
// ----------------------------------------------------------------------------
// empirical_quality_sampler_tb
// Self-checking bench: loads inverse-CDF rows, samples them under several
// register settings and idle patterns, and checks every result beat against
// a behavioral copy of the tables kept in a scoreboard class.
// ----------------------------------------------------------------------------
module empirical_quality_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import eqs_pkg::*;

    localparam int NPOS   = DEF_MAX_POSITIONS;
    localparam int NENT   = DEF_MAX_ENTRIES;
    localparam int SCALE  = DEF_DIST_SCALE;
    localparam int NROWS  = 8 * NPOS;
    localparam int RESULT_W = QUAL_W + 2;

    // status sits above quality in the result beat
    typedef struct packed {
        t_status    status;
        logic [6:0] quality;
    } t_result;

    typedef struct {
        t_op         op;
        logic        rd;
        logic [2:0]  base;
        logic [7:0]  pos;
        logic [31:0] cum;
        logic [31:0] tot;
        logic [6:0]  eq;
        logic [19:0] rnd;
        logic [3:0]  lowq;
    } t_item;

    // Behavioral copy of the sampler tables and registers.
    class quality_scoreboard;
        logic [19:0] thresh [NROWS][NENT];
        logic [6:0]  qual   [NROWS][NENT];
        int          fill   [NROWS];
        t_result     pending [$];
        bit          separate;
        int          shift1, shift2, minq, maxq;
        int          errors;

        function new();
            foreach (fill[i]) fill[i] = 0;
            separate = 0; shift1 = 0; shift2 = 0; minq = 0; maxq = 93;
            errors = 0;
        endfunction

        function void write_reg(t_reg r, logic [31:0] v);
            case (r)
                REG_SEPARATE: separate = v[0];
                REG_SHIFT_1:  shift1 = $signed(v[7:0]);
                REG_SHIFT_2:  shift2 = $signed(v[7:0]);
                REG_MIN_Q:    minq = v[6:0];
                REG_MAX_Q:    maxq = v[6:0];
                default: ;
            endcase
        endfunction

        function logic [19:0] threshold(logic [31:0] c, logic [31:0] t);
            logic [63:0] v;
            if (t == 0) return 20'(SCALE);
            v = (64'(c) * SCALE + t - 1) / t;
            if (v > SCALE) v = SCALE;
            return v[19:0];
        endfunction

        // Update the tables for one accepted beat and queue its result.
        function void note_item(t_item it);
            t_result r;
            int slot, row, f, v;
            bit unknown;
            logic [19:0] th;
            r.quality = 0; r.status = ST_OK;
            slot = 0; unknown = 0;
            if (it.op == OP_CLEAR) begin
                foreach (fill[i]) fill[i] = 0;
            end else if (it.op == OP_LOAD || it.op == OP_SAMPLE) begin
                if (separate) begin
                    if (it.base > 3) unknown = 1;
                    else slot = it.base;
                end
                if (unknown) begin
                    if (it.op == OP_SAMPLE) r.quality = {3'b000, it.lowq};
                end else if (it.pos >= NPOS) begin
                    r.status = ST_POS;
                end else begin
                    row = (it.rd * 4 + slot) * NPOS + it.pos;
                    f = fill[row];
                    if (it.op == OP_LOAD) begin
                        th = threshold(it.cum, it.tot);
                        if (f > 0 && thresh[row][f-1] == th) qual[row][f-1] = it.eq;
                        else if (f >= NENT) r.status = ST_FULL;
                        else begin
                            thresh[row][f] = th; qual[row][f] = it.eq;
                            fill[row] = f + 1;
                        end
                    end else if (f == 0) begin
                        r.status = ST_POS;
                    end else begin
                        r.status = ST_NOENT;
                        for (int i = 0; i < f; i++) begin
                            if (thresh[row][i] >= it.rnd) begin
                                v = qual[row][i] + (it.rd ? shift2 : shift1);
                                if (v < minq) v = minq;
                                if (v > maxq) v = maxq;
                                r.quality = 7'(v);
                                r.status = ST_OK;
                                break;
                            end
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] d);
            t_result exp_r, got;
            got = d[RESULT_W-1:0];
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", d);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.quality !== exp_r.quality) begin
                $error("quality: expected %0d, actual %0d", exp_r.quality, got.quality);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                errors++;
            end
            if (d[15:RESULT_W] !== '0) begin
                $error("fill: expected 0, actual %h", d[15:RESULT_W]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_s_tvalid = 0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    quality_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    empirical_quality_sampler dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Hard stop: clearing sweeps, 64-entry scans and heavy stalls fit well within.
    initial begin
        #20ms;
        $display("empirical_quality_sampler_tb failed");
        $finish;
    end

    // Receiver: stall at random, check each accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic reg_write(t_reg r, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'(4 * int'(r)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(r, v);
    endtask

    // Hold the beat until taken; note it at the accepting edge.
    task automatic send(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= {it.rd, it.op};
        i_s_tdata  <= {6'd0, it.lowq, it.rnd, it.eq, it.tot, it.cum, it.pos, it.base};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(it);
    endtask

    function automatic t_item rand_item();
        t_item it;
        it.op   = t_op'($urandom_range(3));
        it.rd   = 1'($urandom_range(1));
        it.base = 3'($urandom_range(7));
        it.pos  = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(3));
        it.tot  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1000);
        it.cum  = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, it.tot);
        it.eq   = 7'($urandom_range(127));
        it.rnd  = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(0, SCALE));
        it.lowq = 4'($urandom_range(15));
        return it;
    endfunction

    // Load a well-formed row, then sample it.
    task automatic row_burst();
        t_item it;
        int n, tot, cum;
        it = rand_item();
        it.op = OP_LOAD;
        n = ($urandom_range(9) == 0) ? $urandom_range(NENT - 4, NENT + 3) : $urandom_range(1, 6);
        tot = $urandom_range(n, 5000);
        cum = 0;
        for (int i = 0; i < n; i++) begin
            cum = (i == n - 1) ? tot : cum + $urandom_range(0, (tot - cum) / 2);
            it.cum = cum; it.tot = tot; it.eq = 7'($urandom_range(93));
            send(it);
        end
        it.op = OP_SAMPLE;
        for (int i = 0; i < 6; i++) begin
            it.rnd = 20'($urandom_range(0, SCALE));
            it.lowq = 4'($urandom_range(15));
            send(it);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_regs(bit sep, int s1, int s2, int mn, int mx);
        reg_write(REG_SEPARATE, 32'(sep));
        reg_write(REG_SHIFT_1, 32'(s1));
        reg_write(REG_SHIFT_2, 32'(s2));
        reg_write(REG_MIN_Q, 32'(mn));
        reg_write(REG_MAX_Q, 32'(mx));
    endtask

    initial begin
        t_item it;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every operation, special cases.
        it = rand_item();
        it.rd = 0; it.base = 0; it.pos = 0;
        it.op = OP_SAMPLE; it.rnd = 5; send(it);             // empty row
        it.op = OP_LOAD; it.cum = 0; it.tot = 32'hFFFF_FFFF; it.eq = 0; send(it);
        it.cum = 3; it.tot = 10; it.eq = 93; send(it);
        it.cum = 3; it.tot = 10; it.eq = 50; send(it);       // same threshold overwrite
        it.cum = 32'hFFFF_FFFF; it.tot = 1; it.eq = 7; send(it); // saturates
        it.cum = 1; it.tot = 0; it.eq = 9; send(it);          // zero total
        it.cum = 1; it.tot = 100; it.eq = 20; send(it);       // out of order
        it.op = OP_SAMPLE;
        it.rnd = 0; send(it);
        it.rnd = 300000; send(it);
        it.rnd = 20'(SCALE); send(it);
        it.rnd = 20'hFFFFF; send(it);                         // above last threshold
        it.op = OP_NOP; send(it);
        it.op = OP_CLEAR; send(it);
        it.op = OP_SAMPLE; it.rnd = 0; send(it);
        i_s_tvalid <= 0;
        drain();

        // Phases: settings and idle patterns.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(1, -64, 64, 0, 93);
                1: set_regs(0, 64, -64, 93, 0);
                2: set_regs(1, 8'h7F, 8'h80, 127, 127);
                3: set_regs(0, 0, 0, 0, 127);
                default: set_regs(1'($urandom_range(1)), $urandom_range(255),
                                  $urandom_range(255), $urandom_range(127),
                                  $urandom_range(127));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (int k = 0; k < 19; k++) begin
                if ($urandom_range(3) == 0) begin
                    for (int j = 0; j < 3; j++) begin
                        it = rand_item();
                        if (it.op == OP_CLEAR && $urandom_range(3) != 0) it.op = OP_SAMPLE;
                        send(it);
                    end
                end else row_burst();
            end
            i_s_tvalid <= 0;
            drain();
        end

        if (sb.errors == 0) $display("empirical_quality_sampler_tb passed");
        else $display("empirical_quality_sampler_tb failed");
        $finish;
    end
endmodule
